// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and constants shared by the command frame parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

   // Frame delimiters and command range.
   localparam logic [7:0] HDR_A    = 8'hAF;
   localparam logic [7:0] HDR_B    = 8'h45;
   localparam logic [7:0] TAIL_A   = 8'hE1;
   localparam logic [7:0] TAIL_B   = 8'hE2;
   localparam logic [7:0] CMD_LOW  = 8'h01;
   localparam logic [7:0] CMD_HIGH = 8'h05;

   // Command codes.
   localparam logic [2:0] CMD_LINK_CHK = 3'd1;
   localparam logic [2:0] CMD_ON       = 3'd2;
   localparam logic [2:0] CMD_OFF      = 3'd3;
   localparam logic [2:0] CMD_BTN      = 3'd4;
   localparam logic [2:0] CMD_POS      = 3'd5;

   // Only the first bytes of a payload are ever looked at again.
   localparam int unsigned STORE_N  = 5;
   localparam int unsigned STORE_AW = 3;

   // Payload texts, first character in the low byte.
   localparam logic [15:0] TXT_ON    = 16'h4E4F;
   localparam logic [39:0] TXT_OFF_F = 40'h465F46464F;
   localparam logic [39:0] TXT_OFF_D = 40'h445F46464F;
   localparam logic [23:0] TXT_BTN   = 24'h4E5442;

   // Depth of each request and result queue.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_HDR_B  = 3'd1,
      ST_CMD    = 3'd2,
      ST_LEN    = 3'd3,
      ST_BODY   = 3'd4,
      ST_TAIL_B = 3'd5,
      ST_CHECK  = 3'd6
   } cfp_stage_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_PING      = 3'd1,
      ACT_ON        = 3'd2,
      ACT_OFF_FORCE = 3'd3,
      ACT_OFF_DELAY = 3'd4,
      ACT_BUTTON    = 3'd5,
      ACT_POSITION  = 3'd6
   } cfp_action_type;

   // Byte class flags computed by the front end.
   typedef struct packed {
      logic hdr_a;
      logic hdr_b;
      logic cmd_ok;
      logic len_ok;
      logic tail_a;
      logic tail_b;
   } cfp_class_type;

   // One classified request on its way to the engine.
   typedef struct packed {
      logic [7:0]    rx_byte;
      cfp_class_type cls;
   } cfp_entry_type;

   // One result.
   typedef struct packed {
      logic        consumed;
      logic        frame_valid;
      logic        parse_error;
      logic [2:0]  error_stage;
      logic [2:0]  command_code;
      logic [3:0]  payload_length;
      logic [2:0]  action;
      logic [31:0] ping_bytes;
   } cfp_result_type;

endpackage

`default_nettype wire

// ===== rtl/cfp_queue.sv =====
// ----------------------------------------------------------------------------
// cfp_queue
// Small first-in first-out queue with show-ahead read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [0:DEPTH-1];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cfp_front.sv =====
// ----------------------------------------------------------------------------
// cfp_front
// Classifies each received byte against the frame delimiters and ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_front #(
   parameter int unsigned MAX_PAYLOAD = 10
) (
   input  wire logic [7:0]     rx_byte,
   output cfp_pkg::cfp_entry_type entry
);

   // Each flag is a plain compare on the byte.
   always_comb begin
      entry.rx_byte    = rx_byte;
      entry.cls.hdr_a  = (rx_byte == cfp_pkg::HDR_A);
      entry.cls.hdr_b  = (rx_byte == cfp_pkg::HDR_B);
      entry.cls.cmd_ok = (rx_byte >= cfp_pkg::CMD_LOW) && (rx_byte <= cfp_pkg::CMD_HIGH);
      entry.cls.len_ok = ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD));
      entry.cls.tail_a = (rx_byte == cfp_pkg::TAIL_A);
      entry.cls.tail_b = (rx_byte == cfp_pkg::TAIL_B);
   end

endmodule

`default_nettype wire

// ===== rtl/cfp_engine.sv =====
// ----------------------------------------------------------------------------
// cfp_engine
// Frame state machine: running checksum, payload capture and command decode.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_engine #(
   parameter int unsigned MAX_PAYLOAD = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire cfp_pkg::cfp_entry_type entry,
   output logic                       in_take,
   input  wire logic                  out_ready,
   output logic                       out_push,
   output cfp_pkg::cfp_result_type    result
);

   localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

   cfp_pkg::cfp_stage_type  stage_ff, stage_in;
   logic [LEN_W-1:0]        index_ff, index_in;
   logic [LEN_W-1:0]        length_ff, length_in;
   logic [2:0]              command_ff, command_in;
   logic [7:0]              sum_ff, sum_in;
   logic [7:0]              store_ff [0:cfp_pkg::STORE_N-1];
   logic [7:0]              store_in [0:cfp_pkg::STORE_N-1];
   logic [8*cfp_pkg::STORE_N-1:0] store_word;
   logic [LEN_W+3:0]        length_wide;
   logic                    len_is_2, len_is_5;
   cfp_pkg::cfp_action_type action_w;
   logic                    ok;
   logic [7:0]              rx;

   assign in_take     = in_valid && out_ready;
   assign out_push    = in_take;
   assign rx          = entry.rx_byte;
   assign length_wide = {4'b0000, length_ff};
   assign len_is_2    = (length_ff == LEN_W'(2));
   assign len_is_5    = (length_ff == LEN_W'(5));

   // Stored payload bytes as one word, byte 0 in the low bits.
   always_comb begin
      for (int i = 0; i < cfp_pkg::STORE_N; i++) begin
         store_word[8*i +: 8] = store_ff[i];
      end
   end

   // Command decode, with the payload texts checked for on, off and button.
   always_comb begin
      unique case (command_ff)
         cfp_pkg::CMD_LINK_CHK: action_w = cfp_pkg::ACT_PING;
         cfp_pkg::CMD_ON: begin
            action_w = (len_is_2 && store_word[15:0] == cfp_pkg::TXT_ON) ?
                       cfp_pkg::ACT_ON : cfp_pkg::ACT_NONE;
         end
         cfp_pkg::CMD_OFF: begin
            if (len_is_5 && store_word[39:0] == cfp_pkg::TXT_OFF_F) begin
               action_w = cfp_pkg::ACT_OFF_FORCE;
            end else if (len_is_5 && store_word[39:0] == cfp_pkg::TXT_OFF_D) begin
               action_w = cfp_pkg::ACT_OFF_DELAY;
            end else begin
               action_w = cfp_pkg::ACT_NONE;
            end
         end
         cfp_pkg::CMD_BTN: begin
            action_w = (len_is_5 && store_word[23:0] == cfp_pkg::TXT_BTN) ?
                       cfp_pkg::ACT_BUTTON : cfp_pkg::ACT_NONE;
         end
         cfp_pkg::CMD_POS: action_w = cfp_pkg::ACT_POSITION;
         default:          action_w = cfp_pkg::ACT_NONE;
      endcase
   end

   // Next state and the result of the current request.
   always_comb begin
      stage_in   = stage_ff;
      index_in   = index_ff;
      length_in  = length_ff;
      command_in = command_ff;
      sum_in     = sum_ff;
      store_in   = store_ff;
      result     = '0;
      result.consumed = 1'b1;
      ok         = 1'b0;
      unique case (stage_ff)
         cfp_pkg::ST_IDLE: begin
            ok = 1'b1;
            if (entry.cls.hdr_a) begin
               stage_in = cfp_pkg::ST_HDR_B;
            end else begin
               result.consumed = 1'b0;
            end
         end
         cfp_pkg::ST_HDR_B: begin
            if (entry.cls.hdr_b) begin
               stage_in = cfp_pkg::ST_CMD;
               ok       = 1'b1;
            end
         end
         cfp_pkg::ST_CMD: begin
            if (entry.cls.cmd_ok) begin
               command_in = rx[2:0];
               sum_in     = rx;
               stage_in   = cfp_pkg::ST_LEN;
               ok         = 1'b1;
            end
         end
         cfp_pkg::ST_LEN: begin
            if (entry.cls.len_ok) begin
               length_in = rx[LEN_W-1:0];
               sum_in    = sum_ff + rx;
               index_in  = '0;
               stage_in  = cfp_pkg::ST_BODY;
               ok        = 1'b1;
            end
         end
         cfp_pkg::ST_BODY: begin
            if (index_ff == length_ff) begin
               if (entry.cls.tail_a) begin
                  stage_in = cfp_pkg::ST_TAIL_B;
                  ok       = 1'b1;
               end
            end else begin
               if (index_ff < LEN_W'(cfp_pkg::STORE_N)) begin
                  store_in[index_ff[cfp_pkg::STORE_AW-1:0]] = rx;
               end
               index_in = index_ff + 1'b1;
               sum_in   = sum_ff + rx;
               ok       = 1'b1;
            end
         end
         cfp_pkg::ST_TAIL_B: begin
            if (entry.cls.tail_b) begin
               stage_in = cfp_pkg::ST_CHECK;
               ok       = 1'b1;
            end
         end
         cfp_pkg::ST_CHECK: begin
            if (~sum_ff == rx) begin
               result.frame_valid    = 1'b1;
               result.command_code   = command_ff;
               result.payload_length = length_wide[3:0];
               result.action         = action_w;
               result.ping_bytes     = store_word[31:0];
               stage_in              = cfp_pkg::ST_IDLE;
               ok                    = 1'b1;
            end
         end
         default: begin
            stage_in        = cfp_pkg::ST_IDLE;
            result.consumed = 1'b0;
            ok              = 1'b1;
         end
      endcase
      // A broken frame reports its stage and drops back to idle.
      if (!ok) begin
         result.parse_error = 1'b1;
         result.error_stage = stage_ff;
         stage_in           = cfp_pkg::ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= cfp_pkg::ST_IDLE;
         index_ff   <= '0;
         length_ff  <= '0;
         command_ff <= '0;
         sum_ff     <= '0;
         for (int i = 0; i < cfp_pkg::STORE_N; i++) begin
            store_ff[i] <= '0;
         end
      end else if (in_take) begin
         stage_ff   <= stage_in;
         index_ff   <= index_in;
         length_ff  <= length_in;
         command_ff <= command_in;
         sum_ff     <= sum_in;
         store_ff   <= store_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// command_frame_parser
// Byte-serial parser for framed commands with checksum and command decode.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the request queue port: a request is taken at a clock edge
// with req_push high and req_full low. Every request yields exactly one
// result, shown on the rsp_ ports while rsp_empty is low and removed at a
// clock edge with rsp_pop high.
// A front stage classifies each byte and writes it into a two-entry request
// queue; while the result queue has room, the engine takes one request per
// cycle, updates the frame state machine and checksum, and writes the result
// into a two-entry result queue. A taken request is held in the request queue
// and its result in the result queue before it shows on the rsp_ ports.
// Throughput is one request per cycle while the result queue has room.
// When the receiver stops popping, the result queue fills, the engine stops,
// then the request queue fills and req_full rises; nothing is dropped.
// Synchronous reset empties both queues and returns the parser to idle with
// cleared checksum, length, command and stored payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_parser #(
   parameter int unsigned MAX_PAYLOAD = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_rx_byte,
   output logic             req_full,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic             rsp_consumed,
   output logic             rsp_frame_valid,
   output logic             rsp_parse_error,
   output logic [2:0]       rsp_error_stage,
   output logic [2:0]       rsp_command_code,
   output logic [3:0]       rsp_payload_length,
   output logic [2:0]       rsp_action,
   output logic [31:0]      rsp_ping_bytes
);

   localparam int unsigned ENTRY_W  = $bits(cfp_pkg::cfp_entry_type);
   localparam int unsigned RESULT_W = $bits(cfp_pkg::cfp_result_type);

   cfp_pkg::cfp_entry_type  front_entry, queued_entry;
   cfp_pkg::cfp_result_type eng_result, out_result;
   logic                    req_q_empty, eng_take, eng_push, rsp_q_full;

   // Front end classification.
   cfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .rx_byte (req_rx_byte),
      .entry   (front_entry)
   );

   // Queue between front end and engine.
   cfp_queue #(.WIDTH(ENTRY_W), .DEPTH(cfp_pkg::QUEUE_DEPTH)) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_entry),
      .full      (req_full),
      .pop       (eng_take),
      .pop_data  (queued_entry),
      .empty     (req_q_empty)
   );

   // Frame engine.
   cfp_engine #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!req_q_empty),
      .entry     (queued_entry),
      .in_take   (eng_take),
      .out_ready (!rsp_q_full),
      .out_push  (eng_push),
      .result    (eng_result)
   );

   // Result queue toward the receiver.
   cfp_queue #(.WIDTH(RESULT_W), .DEPTH(cfp_pkg::QUEUE_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_data (eng_result),
      .full      (rsp_q_full),
      .pop       (rsp_pop),
      .pop_data  (out_result),
      .empty     (rsp_empty)
   );

   // Result fields onto their ports.
   assign rsp_consumed       = out_result.consumed;
   assign rsp_frame_valid    = out_result.frame_valid;
   assign rsp_parse_error    = out_result.parse_error;
   assign rsp_error_stage    = out_result.error_stage;
   assign rsp_command_code   = out_result.command_code;
   assign rsp_payload_length = out_result.payload_length;
   assign rsp_action         = out_result.action;
   assign rsp_ping_bytes     = out_result.ping_bytes;

endmodule

`default_nettype wire

// ===== rtl/cfp_checker.sv =====
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks on the command frame parser, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_pop,
   input wire logic        rsp_empty,
   input wire logic        rsp_consumed,
   input wire logic        rsp_frame_valid,
   input wire logic        rsp_parse_error,
   input wire logic [2:0]  rsp_error_stage,
   input wire logic [2:0]  rsp_command_code,
   input wire logic [3:0]  rsp_payload_length,
   input wire logic [2:0]  rsp_action,
   input wire logic [31:0] rsp_ping_bytes
);

   // Reset leaves no result waiting.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty)

   // A waiting result that is not taken stays as it is.
   `ASSERT_RST(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_ping_bytes) &&
         $stable(rsp_action) && $stable(rsp_parse_error)))

   // An error or a finished frame always took the byte, and never both.
   `ASSERT_RST(a_err_xor_valid, clock, reset,
      (!rsp_empty && (rsp_parse_error || rsp_frame_valid)) |->
         (rsp_consumed && (rsp_parse_error != rsp_frame_valid)))

   // Errors name a real stage; other results carry no stage.
   `ASSERT_RST(a_err_stage, clock, reset,
      !rsp_empty |-> (rsp_parse_error == (rsp_error_stage != 3'd0)))

   // Frame fields are clear unless a frame finished.
   `ASSERT_RST(a_no_frame_clear, clock, reset,
      (!rsp_empty && !rsp_frame_valid) |->
         (rsp_action == cfp_pkg::ACT_NONE && rsp_command_code == 3'd0 &&
          rsp_ping_bytes == 32'd0 && rsp_payload_length == 4'd0))

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_pop            (rsp_pop),
   .rsp_empty          (rsp_empty),
   .rsp_consumed       (rsp_consumed),
   .rsp_frame_valid    (rsp_frame_valid),
   .rsp_parse_error    (rsp_parse_error),
   .rsp_error_stage    (rsp_error_stage),
   .rsp_command_code   (rsp_command_code),
   .rsp_payload_length (rsp_payload_length),
   .rsp_action         (rsp_action),
   .rsp_ping_bytes     (rsp_ping_bytes)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for command_frame_parser
// Feeds byte streams through the request queue port and checks every result
// against a cycle-free model of the frame state machine, checksum and command
// decode. Directed tests cover each command, text match and error stage, and
// a random phase mixes good frames, broken frames and line noise. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;

   localparam int unsigned PAYLOAD_MAX  = 10;
   localparam int unsigned RANDOM_BYTES = 880;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam longint      TIMEOUT_NS   = 64'd5_000_000;

   // Block ports.
   logic        clock;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_full;
   logic        rsp_pop     = 1'b0;
   logic        rsp_empty;
   logic        rsp_consumed;
   logic        rsp_frame_valid;
   logic        rsp_parse_error;
   logic [2:0]  rsp_error_stage;
   logic [2:0]  rsp_command_code;
   logic [3:0]  rsp_payload_length;
   logic [2:0]  rsp_action;
   logic [31:0] rsp_ping_bytes;

   // Parser state as the model keeps it.
   cfp_pkg::cfp_stage_type frame_stage = cfp_pkg::ST_IDLE;
   logic [3:0]    body_index  = '0;
   logic [2:0]    frame_cmd   = '0;
   logic [3:0]    frame_len   = '0;
   logic [7:0]    frame_sum   = '0;
   logic [7:0]    body_store [PAYLOAD_MAX] = '{default: 8'h00};

   // Results still owed by the block, oldest first.
   cfp_pkg::cfp_result_type pending_results [$];

   // Frame assembly buffers.
   logic [7:0] body_buf  [$];
   logic [7:0] frame_buf [$];

   // Idling control for both sides.
   bit          sender_steady = 1'b0;
   bit          popper_steady = 1'b0;
   int unsigned pop_stall     = 0;

   // Tallies.
   int unsigned fail_count     = 0;
   int unsigned results_seen   = 0;
   int unsigned frames_seen    = 0;
   int unsigned errors_seen    = 0;
   int unsigned actions_seen [7] = '{default: 0};

   command_frame_parser #(
      .MAX_PAYLOAD (PAYLOAD_MAX)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_rx_byte        (req_rx_byte),
      .req_full           (req_full),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_consumed       (rsp_consumed),
      .rsp_frame_valid    (rsp_frame_valid),
      .rsp_parse_error    (rsp_parse_error),
      .rsp_error_stage    (rsp_error_stage),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_action         (rsp_action),
      .rsp_ping_bytes     (rsp_ping_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Compares the first n stored payload bytes with a text, first char low.
   function automatic bit body_matches(input logic [39:0] txt, input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if (body_store[i] != txt[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Decodes a completed frame into its action.
   function automatic cfp_pkg::cfp_action_type decode_action();
      case (frame_cmd)
         cfp_pkg::CMD_LINK_CHK: return cfp_pkg::ACT_PING;
         cfp_pkg::CMD_ON: begin
            return (frame_len == 4'd2 && body_matches(40'(cfp_pkg::TXT_ON), 2)) ?
                   cfp_pkg::ACT_ON : cfp_pkg::ACT_NONE;
         end
         cfp_pkg::CMD_OFF: begin
            if (frame_len == 4'd5 && body_matches(cfp_pkg::TXT_OFF_F, 5))
               return cfp_pkg::ACT_OFF_FORCE;
            if (frame_len == 4'd5 && body_matches(cfp_pkg::TXT_OFF_D, 5))
               return cfp_pkg::ACT_OFF_DELAY;
            return cfp_pkg::ACT_NONE;
         end
         cfp_pkg::CMD_BTN: begin
            return (frame_len == 4'd5 && body_matches(40'(cfp_pkg::TXT_BTN), 3)) ?
                   cfp_pkg::ACT_BUTTON : cfp_pkg::ACT_NONE;
         end
         cfp_pkg::CMD_POS: return cfp_pkg::ACT_POSITION;
         default:          return cfp_pkg::ACT_NONE;
      endcase
   endfunction

   // Advances the parser state by one byte and returns the result it causes.
   function automatic cfp_pkg::cfp_result_type parse_byte(input logic [7:0] b);
      cfp_pkg::cfp_result_type res;
      logic           ok;
      logic [7:0]     inv_sum;
      res = '0;
      res.consumed = 1'b1;
      ok = 1'b0;
      inv_sum = ~frame_sum;
      case (frame_stage)
         cfp_pkg::ST_IDLE: begin
            if (b == cfp_pkg::HDR_A) frame_stage = cfp_pkg::ST_HDR_B;
            else res.consumed = 1'b0;
            ok = 1'b1;
         end
         cfp_pkg::ST_HDR_B: begin
            if (b == cfp_pkg::HDR_B) begin
               frame_stage = cfp_pkg::ST_CMD;
               ok = 1'b1;
            end
         end
         cfp_pkg::ST_CMD: begin
            if (b >= cfp_pkg::CMD_LOW && b <= cfp_pkg::CMD_HIGH) begin
               frame_cmd = b[2:0];
               frame_sum = b;
               frame_stage = cfp_pkg::ST_LEN;
               ok = 1'b1;
            end
         end
         cfp_pkg::ST_LEN: begin
            if (b <= PAYLOAD_MAX) begin
               frame_len = b[3:0];
               frame_sum = frame_sum + b;
               body_index = '0;
               frame_stage = cfp_pkg::ST_BODY;
               ok = 1'b1;
            end
         end
         cfp_pkg::ST_BODY: begin
            if (body_index == frame_len) begin
               if (b == cfp_pkg::TAIL_A) begin
                  frame_stage = cfp_pkg::ST_TAIL_B;
                  ok = 1'b1;
               end
            end else begin
               body_store[body_index] = b;
               body_index = body_index + 4'd1;
               frame_sum = frame_sum + b;
               ok = 1'b1;
            end
         end
         cfp_pkg::ST_TAIL_B: begin
            if (b == cfp_pkg::TAIL_B) begin
               frame_stage = cfp_pkg::ST_CHECK;
               ok = 1'b1;
            end
         end
         cfp_pkg::ST_CHECK: begin
            if (inv_sum == b) begin
               res.frame_valid = 1'b1;
               res.command_code = frame_cmd;
               res.payload_length = frame_len;
               res.action = decode_action();
               res.ping_bytes = {body_store[3], body_store[2], body_store[1],
                                 body_store[0]};
               frame_stage = cfp_pkg::ST_IDLE;
               ok = 1'b1;
            end
         end
         default: begin
            frame_stage = cfp_pkg::ST_IDLE;
            res.consumed = 1'b0;
            ok = 1'b1;
         end
      endcase
      // A broken frame reports where it broke and drops back to idle.
      if (!ok) begin
         res.parse_error = 1'b1;
         res.error_stage = frame_stage;
         frame_stage = cfp_pkg::ST_IDLE;
      end
      return res;
   endfunction

   // Sender gap: mostly none or short, a few long, with calm stretches.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) sender_steady = !sender_steady;
      if (sender_steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Receiver pop decision, with stalls of random length.
   function automatic logic pick_pop();
      int unsigned r;
      if (pop_stall != 0) begin
         pop_stall--;
         return 1'b0;
      end
      if ($urandom_range(0, 49) == 0) popper_steady = !popper_steady;
      if (popper_steady) return 1'b1;
      r = $urandom_range(0, 99);
      if (r < 65) return 1'b1;
      if (r < 92) pop_stall = $urandom_range(0, 2);
      else if (r < 98) pop_stall = $urandom_range(3, 10);
      else pop_stall = $urandom_range(20, 40);
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Predicts each accepted request and checks each popped result.
   always @(posedge clock) begin
      cfp_pkg::cfp_result_type got;
      cfp_pkg::cfp_result_type want;
      if (!reset) begin
         if (req_push && !req_full) pending_results.push_back(parse_byte(req_rx_byte));
         if (rsp_pop && !rsp_empty) begin
            got.consumed       = rsp_consumed;
            got.frame_valid    = rsp_frame_valid;
            got.parse_error    = rsp_parse_error;
            got.error_stage    = rsp_error_stage;
            got.command_code   = rsp_command_code;
            got.payload_length = rsp_payload_length;
            got.action         = rsp_action;
            got.ping_bytes     = rsp_ping_bytes;
            if (pending_results.size() == 0) begin
               $error("result popped with no request outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("consumed", 32'(want.consumed), 32'(got.consumed));
               check_field("frame_valid", 32'(want.frame_valid), 32'(got.frame_valid));
               check_field("parse_error", 32'(want.parse_error), 32'(got.parse_error));
               check_field("error_stage", 32'(want.error_stage), 32'(got.error_stage));
               check_field("command_code", 32'(want.command_code),
                           32'(got.command_code));
               check_field("payload_length", 32'(want.payload_length),
                           32'(got.payload_length));
               check_field("action", 32'(want.action), 32'(got.action));
               check_field("ping_bytes", want.ping_bytes, got.ping_bytes);
               results_seen++;
               if (want.frame_valid) begin
                  frames_seen++;
                  actions_seen[want.action]++;
               end
               if (want.parse_error) errors_seen++;
            end
         end
      end
      rsp_pop <= reset ? 1'b0 : pick_pop();
   end

   // Sends one request, holding it until the block takes it.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_frame_buf();
      foreach (frame_buf[i]) send_byte(frame_buf[i]);
   endtask

   // Fills the payload with n text characters followed by random bytes.
   function automatic void set_body(input logic [39:0] txt, input int unsigned n,
                                    input int unsigned total);
      body_buf.delete();
      for (int unsigned i = 0; i < total; i++) begin
         body_buf.push_back(i < n ? txt[8*i +: 8] : 8'($urandom_range(0, 255)));
      end
   endfunction

   // Builds a well-formed frame around the current payload.
   function automatic void build_frame(input logic [7:0] cmd_b);
      logic [7:0] sum;
      sum = cmd_b + 8'(body_buf.size());
      frame_buf.delete();
      frame_buf.push_back(cfp_pkg::HDR_A);
      frame_buf.push_back(cfp_pkg::HDR_B);
      frame_buf.push_back(cmd_b);
      frame_buf.push_back(8'(body_buf.size()));
      foreach (body_buf[i]) begin
         frame_buf.push_back(body_buf[i]);
         sum = sum + body_buf[i];
      end
      frame_buf.push_back(cfp_pkg::TAIL_A);
      frame_buf.push_back(cfp_pkg::TAIL_B);
      frame_buf.push_back(~sum);
   endfunction

   task automatic send_text_frame(input logic [7:0] cmd_b, input logic [39:0] txt,
                                  input int unsigned n, input int unsigned total);
      set_body(txt, n, total);
      build_frame(cmd_b);
      send_frame_buf();
   endtask

   // Bytes outside a frame, including the extremes, are ignored.
   task automatic test_idle_noise();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cfp_pkg::HDR_B);
      send_byte(cfp_pkg::TAIL_A);
   endtask

   // Every command with the payload text that selects its action.
   task automatic test_commands();
      send_text_frame({5'd0, cfp_pkg::CMD_LINK_CHK}, '0, 0, 0);
      send_text_frame({5'd0, cfp_pkg::CMD_ON}, 40'(cfp_pkg::TXT_ON), 2, 2);
      send_text_frame({5'd0, cfp_pkg::CMD_OFF}, cfp_pkg::TXT_OFF_F, 5, 5);
      send_text_frame({5'd0, cfp_pkg::CMD_OFF}, cfp_pkg::TXT_OFF_D, 5, 5);
      send_text_frame({5'd0, cfp_pkg::CMD_BTN}, 40'(cfp_pkg::TXT_BTN), 3, 5);
      // Longest payload with both extreme byte values.
      set_body('0, 0, PAYLOAD_MAX);
      body_buf[0] = 8'h00;
      body_buf[1] = 8'hFF;
      build_frame({5'd0, cfp_pkg::CMD_POS});
      send_frame_buf();
   endtask

   // Near misses of the texts decode to no action.
   task automatic test_text_mismatch();
      send_text_frame({5'd0, cfp_pkg::CMD_ON}, 40'h464F, 2, 2);
      send_text_frame({5'd0, cfp_pkg::CMD_ON}, 40'(cfp_pkg::TXT_ON), 2, 3);
      send_text_frame({5'd0, cfp_pkg::CMD_OFF}, cfp_pkg::TXT_OFF_F, 4, 4);
      send_text_frame({5'd0, cfp_pkg::CMD_OFF}, 40'h585F46464F, 5, 5);
      send_text_frame({5'd0, cfp_pkg::CMD_BTN}, 40'h585442, 3, 5);
      send_text_frame({5'd0, cfp_pkg::CMD_BTN}, 40'(cfp_pkg::TXT_BTN), 3, 3);
   endtask

   // A short frame still shows the bytes left behind by the one before.
   task automatic test_stale_payload();
      send_text_frame({5'd0, cfp_pkg::CMD_LINK_CHK}, 40'h44332211, 4, 4);
      send_text_frame({5'd0, cfp_pkg::CMD_LINK_CHK}, 40'hAA, 1, 1);
      send_text_frame({5'd0, cfp_pkg::CMD_LINK_CHK}, '0, 0, 0);
   endtask

   // A broken frame at every stage.
   task automatic test_stage_errors();
      // A second first-header byte breaks the frame and is not a new start.
      send_byte(cfp_pkg::HDR_A);
      send_byte(cfp_pkg::HDR_A);
      send_byte(cfp_pkg::HDR_B);
      set_body('0, 0, 2);
      build_frame({5'd0, cfp_pkg::CMD_LINK_CHK});
      frame_buf[2] = 8'h00;
      send_frame_buf();
      frame_buf[2] = 8'h06;
      send_frame_buf();
      frame_buf[2] = 8'hFF;
      send_frame_buf();
      build_frame({5'd0, cfp_pkg::CMD_LINK_CHK});
      frame_buf[3] = 8'(PAYLOAD_MAX + 1);
      send_frame_buf();
      frame_buf[3] = 8'hFF;
      send_frame_buf();
      // Tail and checksum errors; the two-byte payload fixes their positions.
      build_frame({5'd0, cfp_pkg::CMD_LINK_CHK});
      frame_buf[6] = 8'h00;
      send_frame_buf();
      build_frame({5'd0, cfp_pkg::CMD_LINK_CHK});
      frame_buf[7] = cfp_pkg::TAIL_A;
      send_frame_buf();
      build_frame({5'd0, cfp_pkg::CMD_LINK_CHK});
      frame_buf[8] = frame_buf[8] ^ 8'h01;
      send_frame_buf();
   endtask

   // Mostly good frames with random content, plus broken frames and noise.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      int unsigned noise_n;
      logic [7:0]  cmd_b;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         pick  = $urandom_range(0, 99);
         cmd_b = 8'($urandom_range(cfp_pkg::CMD_LOW, cfp_pkg::CMD_HIGH));
         len   = $urandom_range(0, PAYLOAD_MAX);
         if (pick < 85) begin
            // Now and then the payload carries the text for its command.
            if ($urandom_range(0, 2) == 0) begin
               case (cmd_b[2:0])
                  cfp_pkg::CMD_ON:  set_body(40'(cfp_pkg::TXT_ON), 2, 2);
                  cfp_pkg::CMD_OFF: begin
                     set_body($urandom_range(0, 1) ? cfp_pkg::TXT_OFF_F :
                              cfp_pkg::TXT_OFF_D, 5, 5);
                  end
                  cfp_pkg::CMD_BTN: set_body(40'(cfp_pkg::TXT_BTN), 3, 5);
                  default:          set_body('0, 0, len);
               endcase
            end else begin
               set_body('0, 0, len);
            end
            build_frame(cmd_b);
            if (pick >= 70) begin
               frame_buf[$urandom_range(1, frame_buf.size() - 1)] =
                  8'($urandom_range(0, 255));
            end
            send_frame_buf();
            sent += frame_buf.size();
         end else begin
            noise_n = $urandom_range(1, 6);
            repeat (noise_n) begin
               send_byte($urandom_range(0, 3) == 0 ? cfp_pkg::HDR_A :
                         8'($urandom_range(0, 255)));
            end
            sent += noise_n;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_noise();
      test_commands();
      test_text_mismatch();
      test_stale_payload();
      test_stage_errors();
      test_random_traffic();
      // Let every outstanding result drain before the verdict.
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results: %0d good frames, %0d broken frames.",
               results_seen, frames_seen, errors_seen);
      $display("Actions: none %0d, ping %0d, on %0d, forced off %0d,",
               actions_seen[0], actions_seen[1], actions_seen[2], actions_seen[3]);
      $display("         delayed off %0d, button %0d, position %0d.",
               actions_seen[4], actions_seen[5], actions_seen[6]);
      if (fail_count == 0) begin
         $display("** command_frame_parser: PASSED **");
      end else begin
         $display("** command_frame_parser: FAILED **");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("** command_frame_parser: FAILED **");
      $finish;
   end

endmodule
